[hdl/stls_pkg.sv]
package stls_pkg;

  // Slot number width and output byte width are fixed by the stream format
  localparam int unsigned ID_BITS       = 3;
  localparam int unsigned CMD_BITS      = 2;
  localparam int unsigned OUT_DATA_BITS = 8;

  // Request kinds carried in tuser; the fourth code is ignored
  typedef enum logic [CMD_BITS-1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  // What a list cell does on the next clock edge
  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_LOAD       = 3'd1,
    OP_UPDATE     = 3'd2,
    OP_RESTART    = 3'd3,
    OP_TAKE_LEFT  = 3'd4,
    OP_TAKE_RIGHT = 3'd5
  } cell_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

endpackage

[hdl/stls_cell.sv]
module stls_cell #(
  parameter int unsigned TICK_BITS    = 32,
  parameter int unsigned TIMEOUT_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stls_pkg::cell_op_e            op_i,
  input  logic [TICK_BITS-1:0]          tick_i,
  // new entry written by a start request
  input  logic [stls_pkg::ID_BITS-1:0]  new_id_i,
  input  logic [TIMEOUT_BITS-1:0]       new_timeout_i,
  input  logic                          new_once_i,
  // neighbour towards the head of the list
  input  logic                          left_valid_i,
  input  logic [stls_pkg::ID_BITS-1:0]  left_id_i,
  input  logic [TIMEOUT_BITS-1:0]       left_timeout_i,
  input  logic [TICK_BITS-1:0]          left_start_i,
  input  logic                          left_once_i,
  // neighbour towards the tail of the list
  input  logic                          right_valid_i,
  input  logic [stls_pkg::ID_BITS-1:0]  right_id_i,
  input  logic [TIMEOUT_BITS-1:0]       right_timeout_i,
  input  logic [TICK_BITS-1:0]          right_start_i,
  input  logic                          right_once_i,
  // stored entry
  output logic                          valid_o,
  output logic [stls_pkg::ID_BITS-1:0]  id_o,
  output logic [TIMEOUT_BITS-1:0]       timeout_o,
  output logic [TICK_BITS-1:0]          start_o,
  output logic                          once_o,
  // local decisions
  output logic                          expired_o,
  output logic                          stay_o
);
  import stls_pkg::*;

  localparam int unsigned CMP_BITS = (TICK_BITS > TIMEOUT_BITS) ? TICK_BITS : TIMEOUT_BITS;

  logic                    valid_q, valid_d;
  logic [ID_BITS-1:0]      id_q, id_d;
  logic [TIMEOUT_BITS-1:0] timeout_q, timeout_d;
  logic [TICK_BITS-1:0]    start_q, start_d;
  logic                    once_q, once_d;
  logic [TICK_BITS-1:0]    elapsed;

  // Next entry contents
  always_comb begin
    valid_d   = valid_q;
    id_d      = id_q;
    timeout_d = timeout_q;
    start_d   = start_q;
    once_d    = once_q;
    unique case (op_i)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        valid_d   = 1'b1;
        id_d      = new_id_i;
        timeout_d = new_timeout_i;
        start_d   = tick_i;
        once_d    = new_once_i;
      end
      OP_UPDATE: begin
        timeout_d = new_timeout_i;
        start_d   = tick_i;
        once_d    = new_once_i;
      end
      OP_RESTART: begin
        start_d = tick_i;
      end
      OP_TAKE_LEFT: begin
        valid_d   = left_valid_i;
        id_d      = left_id_i;
        timeout_d = left_timeout_i;
        start_d   = left_start_i;
        once_d    = left_once_i;
      end
      OP_TAKE_RIGHT: begin
        valid_d   = right_valid_i;
        id_d      = right_id_i;
        timeout_d = right_timeout_i;
        start_d   = right_start_i;
        once_d    = right_once_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    id_q      <= id_d;
    timeout_q <= timeout_d;
    start_q   <= start_d;
    once_q    <= once_d;
  end

  // Elapsed ticks wrap with the counter
  assign elapsed   = tick_i - start_q;
  assign expired_o = valid_q && (CMP_BITS'(elapsed) >= CMP_BITS'(timeout_q));
  // entry stays ahead of a new one with a longer timeout
  assign stay_o    = valid_q && (timeout_q < new_timeout_i);

  assign valid_o   = valid_q;
  assign id_o      = id_q;
  assign timeout_o = timeout_q;
  assign start_o   = start_q;
  assign once_o    = once_q;

endmodule

[hdl/sorted_timer_list_scheduler_top.sv]
// Timer list ordered by timeout length, held in a row of cells, one list entry per cell
// with its slot number, timeout, start tick and one-shot flag. On start and stop requests
// every cell decides from its own compare and its neighbours whether to keep, load, or
// shift, so insertion and removal move the whole row together. A tick request is accepted
// and then starts a scan that walks a position pointer down the row; each expiry is one
// result on the master side, tlast marking the final one of the tick, and a stalled
// master side holds the scan. A new request is taken once the scan has finished. Slots
// whose number is not below NUM_TIMERS are ignored, as is the unused request code.
module sorted_timer_list_scheduler_top #(
  parameter int unsigned NUM_TIMERS   = 8,
  parameter int unsigned TICK_BITS    = 32,
  parameter int unsigned TIMEOUT_BITS = 24,
  localparam int unsigned S_DATA_BITS = ((stls_pkg::ID_BITS + TIMEOUT_BITS + 1 + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // timer_id, timeout_ticks, once_flag, zero padding
  input  logic [S_DATA_BITS-1:0]              s_axis_tdata,
  // cmd
  input  logic [stls_pkg::CMD_BITS-1:0]       s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // fired_id, zero padding
  output logic [stls_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  output logic                                m_axis_tlast
);
  import stls_pkg::*;

  localparam int unsigned POS_BITS = $clog2(NUM_TIMERS + 1);

  // Request fields
  logic                    in_accept;
  logic [ID_BITS-1:0]      in_id;
  logic [TIMEOUT_BITS-1:0] in_timeout;
  logic                    in_once;
  logic                    id_ok;
  cmd_e                    in_cmd;

  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign in_id      = s_axis_tdata[ID_BITS-1:0];
  assign in_timeout = s_axis_tdata[ID_BITS +: TIMEOUT_BITS];
  assign in_once    = s_axis_tdata[ID_BITS+TIMEOUT_BITS];
  assign in_cmd     = cmd_e'(s_axis_tuser);
  assign id_ok      = (32'(in_id) < 32'(NUM_TIMERS));

  // Control registers
  state_e                state_q, state_d;
  logic [POS_BITS-1:0]   pos_q, pos_d;
  logic [TICK_BITS-1:0]  tick_q, tick_d;
  logic                  out_valid_q, out_valid_d;
  logic [ID_BITS-1:0]    fired_q, fired_d;
  logic                  last_q, last_d;

  // Cell row
  cell_op_e                cop   [NUM_TIMERS];
  logic                    cv    [NUM_TIMERS];
  logic [ID_BITS-1:0]      cid   [NUM_TIMERS];
  logic [TIMEOUT_BITS-1:0] ctout [NUM_TIMERS];
  logic [TICK_BITS-1:0]    cstart[NUM_TIMERS];
  logic                    conce [NUM_TIMERS];
  logic                    cexp  [NUM_TIMERS];
  logic                    cstay [NUM_TIMERS];
  logic                    match [NUM_TIMERS];

  for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
    logic                    lv, rv, lo, ro;
    logic [ID_BITS-1:0]      li, ri;
    logic [TIMEOUT_BITS-1:0] lt, rt;
    logic [TICK_BITS-1:0]    ls, rs;

    if (k == 0) begin : g_head
      assign lv = 1'b0;
      assign li = '0;
      assign lt = '0;
      assign ls = '0;
      assign lo = 1'b0;
    end else begin : g_mid_l
      assign lv = cv[k-1];
      assign li = cid[k-1];
      assign lt = ctout[k-1];
      assign ls = cstart[k-1];
      assign lo = conce[k-1];
    end

    if (k == NUM_TIMERS - 1) begin : g_tail
      assign rv = 1'b0;
      assign ri = '0;
      assign rt = '0;
      assign rs = '0;
      assign ro = 1'b0;
    end else begin : g_mid_r
      assign rv = cv[k+1];
      assign ri = cid[k+1];
      assign rt = ctout[k+1];
      assign rs = cstart[k+1];
      assign ro = conce[k+1];
    end

    stls_cell #(
      .TICK_BITS    (TICK_BITS),
      .TIMEOUT_BITS (TIMEOUT_BITS)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .op_i            (cop[k]),
      .tick_i          (tick_q),
      .new_id_i        (in_id),
      .new_timeout_i   (in_timeout),
      .new_once_i      (in_once),
      .left_valid_i    (lv),
      .left_id_i       (li),
      .left_timeout_i  (lt),
      .left_start_i    (ls),
      .left_once_i     (lo),
      .right_valid_i   (rv),
      .right_id_i      (ri),
      .right_timeout_i (rt),
      .right_start_i   (rs),
      .right_once_i    (ro),
      .valid_o         (cv[k]),
      .id_o            (cid[k]),
      .timeout_o       (ctout[k]),
      .start_o         (cstart[k]),
      .once_o          (conce[k]),
      .expired_o       (cexp[k]),
      .stay_o          (cstay[k])
    );

    assign match[k] = cv[k] && (cid[k] == in_id);
  end

  // Slot already in the list
  logic hit;
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < NUM_TIMERS; k++) begin
      hit = hit | match[k];
    end
  end

  // Entry under the scan pointer and the one after it
  logic               head_exp, head_once, next_exp;
  logic [ID_BITS-1:0] head_id;
  always_comb begin
    head_exp  = 1'b0;
    head_once = 1'b0;
    head_id   = '0;
    next_exp  = 1'b0;
    for (int k = 0; k < NUM_TIMERS; k++) begin
      if (POS_BITS'(k) == pos_q) begin
        head_exp  = cexp[k];
        head_once = conce[k];
        head_id   = cid[k];
      end
      if ((POS_BITS + 1)'(k) == ({1'b0, pos_q} + (POS_BITS + 1)'(1))) begin
        next_exp = cexp[k];
      end
    end
  end

  logic can_step, scan_emit, do_start, do_stop, do_tick;
  assign can_step  = !out_valid_q || m_axis_tready;
  assign scan_emit = (state_q == ST_SCAN) && head_exp && can_step;

  // Request decode
  always_comb begin
    do_start = 1'b0;
    do_stop  = 1'b0;
    do_tick  = 1'b0;
    if (in_accept) begin
      unique case (in_cmd)
        CMD_START: do_start = id_ok;
        CMD_STOP:  do_stop  = id_ok;
        CMD_TICK:  do_tick  = 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Cell operations: insertion shifts right, removal shifts left
  always_comb begin
    logic ins_seen;
    logic rm_seen;
    ins_seen = 1'b0;
    rm_seen  = 1'b0;
    for (int k = 0; k < NUM_TIMERS; k++) begin
      cop[k] = OP_HOLD;
      if (do_start) begin
        if (hit) begin
          if (match[k]) begin
            cop[k] = OP_UPDATE;
          end
        end else if (ins_seen) begin
          cop[k] = OP_TAKE_LEFT;
        end else if (!cstay[k]) begin
          cop[k] = OP_LOAD;
        end
      end else if (do_stop) begin
        if (rm_seen || match[k]) begin
          cop[k] = OP_TAKE_RIGHT;
        end
      end else if (scan_emit) begin
        if (head_once) begin
          if (POS_BITS'(k) >= pos_q) begin
            cop[k] = OP_TAKE_RIGHT;
          end
        end else if (POS_BITS'(k) == pos_q) begin
          cop[k] = OP_RESTART;
        end
      end
      ins_seen = ins_seen | !cstay[k];
      rm_seen  = rm_seen | match[k];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (do_tick) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!head_exp) begin
          state_d = ST_IDLE;
        end else if (can_step && !next_exp) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    pos_d         = pos_q;
    tick_d        = tick_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    fired_d       = fired_q;
    last_d        = last_q;
    if (do_tick) begin
      tick_d = tick_q + TICK_BITS'(1);
      pos_d  = '0;
    end
    if (scan_emit) begin
      out_valid_d = 1'b1;
      fired_d     = head_id;
      last_d      = !next_exp;
      if (!head_once) begin
        pos_d = pos_q + POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fired_q <= fired_d;
    last_q  <= last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_BITS - ID_BITS){1'b0}}, fired_q};
  assign m_axis_tlast  = last_q;

endmodule

[test/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stls_pkg::*;

  localparam int unsigned NUM_SLOTS   = 8;
  localparam int unsigned TOUT_W      = 24;
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned IN_W        = 32;
  localparam int unsigned IDLE_PCT    = 9;
  localparam int unsigned STALL_LEN   = 300;
  localparam int unsigned DRAIN_WAIT  = 4 * NUM_SLOTS;
  localparam int unsigned MAX_PRINTED = 40;
  // request code the block must ignore
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam logic [TOUT_W-1:0]   TOUT_MAX   = {TOUT_W{1'b1}};

  typedef struct {
    logic [ID_BITS-1:0] id;
    logic               last;
  } expiry_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // timer_id, timeout_ticks, once_flag, zero padding
  logic [IN_W-1:0]          s_axis_tdata  = '0;
  // cmd
  logic [CMD_BITS-1:0]      s_axis_tuser  = CMD_START;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // fired_id, zero padding
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tlast;

  // Predicted state of the timer list
  logic [TICK_W-1:0]  tick_count;
  logic [NUM_SLOTS-1:0] slot_live;
  logic [NUM_SLOTS-1:0] slot_once;
  logic [TOUT_W-1:0]  slot_tout  [NUM_SLOTS];
  logic [TICK_W-1:0]  slot_since [NUM_SLOTS];
  logic [ID_BITS-1:0] run_order  [$];

  expiry_t     pending_expiries [$];
  int unsigned err_count   = 0;
  int unsigned n_requests  = 0;
  int unsigned n_ticks     = 0;
  int unsigned n_fired     = 0;
  bit          steady      = 1'b0;
  bit          stall_req   = 1'b0;

  sorted_timer_list_scheduler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("tb_top: MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Ordered insertion: goes in front of the first entry with equal or longer timeout
  function automatic void list_insert(input logic [ID_BITS-1:0] id);
    int unsigned pos;
    pos = 0;
    while (pos < run_order.size() && slot_tout[run_order[pos]] < slot_tout[id]) pos++;
    run_order.insert(pos, id);
  endfunction

  // Apply one accepted request to the predicted list and queue the expiries it causes
  function automatic void advance_timer_list(input logic [CMD_BITS-1:0] cmd,
                                             input logic [ID_BITS-1:0] id,
                                             input logic [TOUT_W-1:0] tout,
                                             input logic once);
    int unsigned pos;
    int unsigned fired;
    logic [ID_BITS-1:0] cur;
    expiry_t hit;
    case (cmd)
      CMD_START: begin
        slot_since[id] = tick_count;
        slot_tout[id]  = tout;
        slot_once[id]  = once;
        if (!slot_live[id]) begin
          slot_live[id] = 1'b1;
          list_insert(id);
        end
      end
      CMD_STOP: begin
        slot_live[id] = 1'b0;
        foreach (run_order[i]) begin
          if (run_order[i] == id) begin
            run_order.delete(i);
            break;
          end
        end
      end
      CMD_TICK: begin
        tick_count = tick_count + 1'b1;
        pos = 0;
        fired = 0;
        while (pos < run_order.size()) begin
          cur = run_order[pos];
          if (TICK_W'(tick_count - slot_since[cur]) < {{(TICK_W-TOUT_W){1'b0}}, slot_tout[cur]})
            break;
          hit.id   = cur;
          hit.last = 1'b0;
          pending_expiries.push_back(hit);
          fired++;
          if (slot_once[cur]) begin
            slot_live[cur] = 1'b0;
            run_order.delete(pos);
          end else begin
            slot_since[cur] = tick_count;
            pos++;
          end
        end
        if (fired > 0) pending_expiries[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Offer one request; returns at the falling edge after it was taken, valid left high
  task automatic send_request(input logic [CMD_BITS-1:0] cmd, input logic [ID_BITS-1:0] id,
                              input logic [TOUT_W-1:0] tout, input logic once);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_W-ID_BITS-TOUT_W-1){1'b0}}, once, tout, id};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_timer_list(cmd, id, tout, once);
    n_requests++;
    if (cmd == CMD_TICK) n_ticks++;
    @(negedge clk_i);
  endtask

  // Receiver: random hold-offs, plus one long stall on demand
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        stall_left = STALL_LEN;
        stall_req  = 1'b0;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    expiry_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_expiries.size() == 0) begin
        flag_error($sformatf("unexpected expiry id %0d", m_axis_tdata[ID_BITS-1:0]));
      end else begin
        want = pending_expiries.pop_front();
        n_fired++;
        if (m_axis_tdata[ID_BITS-1:0] !== want.id)
          flag_error($sformatf("fired_id %0d, expected %0d",
                               m_axis_tdata[ID_BITS-1:0], want.id));
        if (m_axis_tdata[OUT_DATA_BITS-1:ID_BITS] !== '0)
          flag_error($sformatf("padding bits %b not zero", m_axis_tdata[OUT_DATA_BITS-1:ID_BITS]));
        if (m_axis_tlast !== want.last)
          flag_error($sformatf("tlast %b, expected %b (id %0d)", m_axis_tlast, want.last, want.id));
      end
    end
  end

  // Basic commands, field extremes and the corner cases of the list
  task automatic test_commands();
    send_request(CMD_UNUSED, 3'd5, TOUT_MAX, 1'b1);
    send_request(CMD_STOP, 3'd2, '0, 1'b0);              // stop of an idle slot
    send_request(CMD_TICK, 3'd0, '0, 1'b0);              // empty list
    send_request(CMD_START, 3'd0, '0, 1'b0);             // zero timeout fires every tick
    send_request(CMD_TICK, 3'd0, '0, 1'b0);
    send_request(CMD_START, 3'd7, TOUT_MAX, 1'b1);
    send_request(CMD_START, 3'd3, 24'd2, 1'b0);
    send_request(CMD_TICK, 3'd0, '0, 1'b0);
    send_request(CMD_TICK, 3'd0, '0, 1'b0);
    send_request(CMD_START, 3'd3, '0, 1'b1);             // restart keeps list position
    send_request(CMD_TICK, 3'd0, '0, 1'b0);
    send_request(CMD_STOP, 3'd0, '0, 1'b0);
    send_request(CMD_STOP, 3'd7, '0, 1'b0);
    send_request(CMD_TICK, 3'd0, '0, 1'b0);
    send_request(CMD_START, 3'd5, 24'd1, 1'b1);
    send_request(CMD_TICK, 3'd0, '0, 1'b0);
  endtask

  // Every slot live at once: a tick with the most expiries, one-shots dropping mid-scan
  task automatic test_full_list();
    for (int i = NUM_SLOTS - 1; i >= 0; i--) send_request(CMD_START, ID_BITS'(i), '0, i[0]);
    send_request(CMD_TICK, 3'd0, '0, 1'b0);
    send_request(CMD_TICK, 3'd0, '0, 1'b0);
  endtask

  // Long receiver stall while ticks keep coming, so the request side must back up
  task automatic test_backpressure();
    send_request(CMD_START, 3'd2, '0, 1'b0);
    stall_req = 1'b1;
    repeat (8) send_request(CMD_TICK, 3'd0, '0, 1'b0);
  endtask

  // Mostly short timeouts so the list fills and fires; the first third runs without gaps
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned        pick;
    logic [ID_BITS-1:0] id;
    logic [TOUT_W-1:0]  tout;
    for (int unsigned i = 0; i < n_items; i++) begin
      steady = (i < n_items / 3);
      pick = $urandom_range(99);
      id   = ID_BITS'($urandom_range(NUM_SLOTS - 1));
      tout = ($urandom_range(9) == 0) ? TOUT_W'($urandom) : TOUT_W'($urandom_range(6));
      if (pick < 40)      send_request(CMD_START, id, tout, 1'($urandom_range(1)));
      else if (pick < 50) send_request(CMD_STOP, id, TOUT_W'($urandom), 1'($urandom_range(1)));
      else if (pick < 97) send_request(CMD_TICK, id, TOUT_W'($urandom), 1'($urandom_range(1)));
      else                send_request(CMD_UNUSED, id, TOUT_W'($urandom), 1'($urandom_range(1)));
    end
    steady = 1'b0;
  endtask

  initial begin
    tick_count = '0;
    slot_live  = '0;
    slot_once  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_commands();
    test_full_list();
    test_backpressure();
    test_random_traffic(420);

    s_axis_tvalid <= 1'b0;
    while (pending_expiries.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("tb_top: %0d requests sent (%0d ticks), %0d expiries checked", n_requests,
             n_ticks, n_fired);
    $display("tb_top: covered restarts, stops, ignored codes, full list and a long stall");
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
